### hdl/tlpc_pkg.sv
// Shared types, register indexes, reset values and phase codes for the
// traffic light / pedestrian controller. No dependencies.
`timescale 1ns / 1ps

package tlpc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;
    localparam int SLOT_MS_W   = 10;
    localparam int SLOTS_W     = 7;
    localparam int WARN_MS_W   = 14;
    localparam int BEEP_MS_W   = 10;
    localparam int MS_W        = 14;
    localparam int BEEP_CNT_W  = 5;

    localparam logic [BEEP_CNT_W-1:0] BEEP_CYCLES = 5'd20;
    localparam logic [BEEP_CNT_W-1:0] BEEP_CNT_MAX = 5'd31;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_SLOT_MS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_SLOTS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_YELLOW_SLOT_MS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_YELLOW_SLOTS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_SLOT_MS    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_SLOTS      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WARN_MS        = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_BEEP_HALF_MS   = 3'd7;

    localparam logic [SLOT_MS_W-1:0] RST_GREEN_SLOT_MS  = 10'd80;
    localparam logic [SLOTS_W-1:0]   RST_GREEN_SLOTS    = 7'd100;
    localparam logic [SLOT_MS_W-1:0] RST_YELLOW_SLOT_MS = 10'd40;
    localparam logic [SLOTS_W-1:0]   RST_YELLOW_SLOTS   = 7'd50;
    localparam logic [SLOT_MS_W-1:0] RST_RED_SLOT_MS    = 10'd100;
    localparam logic [SLOTS_W-1:0]   RST_RED_SLOTS      = 7'd100;
    localparam logic [WARN_MS_W-1:0] RST_WARN_MS        = 14'd5000;
    localparam logic [BEEP_MS_W-1:0] RST_BEEP_HALF_MS   = 10'd375;

    typedef enum logic [2:0] {
        PH_GREEN    = 3'd0,
        PH_YELLOW   = 3'd1,
        PH_RED      = 3'd2,
        PH_WARN     = 3'd3,
        PH_BEEP_ON  = 3'd4,
        PH_BEEP_OFF = 3'd5,
        PH_RESUME   = 3'd6
    } phase_t;

    typedef struct packed {
        logic [SLOT_MS_W-1:0] green_slot_ms;
        logic [SLOTS_W-1:0]   green_slots;
        logic [SLOT_MS_W-1:0] yellow_slot_ms;
        logic [SLOTS_W-1:0]   yellow_slots;
        logic [SLOT_MS_W-1:0] red_slot_ms;
        logic [SLOTS_W-1:0]   red_slots;
        logic [WARN_MS_W-1:0] warn_ms;
        logic [BEEP_MS_W-1:0] beep_half_ms;
    } cfg_t;

endpackage

### hdl/traffic_light_pedestrian_controller_top.sv
// Top level of the traffic light / pedestrian controller: input register,
// one-tick phase logic and result register. Depends on tlpc_pkg, tlpc_cfg_regs.
`timescale 1ns / 1ps

// Each input request is one millisecond tick carrying the sampled button
// level; each tick yields exactly one result request with the lamp drives,
// buzzer level and phase code for that millisecond. One tick is taken every
// clock cycle while the result register can drain; a tick is registered on
// input, and the whole phase/counter update runs combinationally between the
// input register and the result register.
// The result register is refilled in the same cycle it is drained, so
// output back-pressure only stalls the input when both registers are full.
// Configuration writes are always accepted and take effect on the next tick.
module traffic_light_pedestrian_controller_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [0] button_pressed
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] red_lamp, [1] yellow_lamp, [2] green_lamp, [3] walk_lamp,
    // [4] buzzer_on, [7:5] phase
    output logic [7:0]                       m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tlpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tlpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int MS_W    = tlpc_pkg::MS_W;
    localparam int SLOTS_W = tlpc_pkg::SLOTS_W;
    localparam int BC_W    = tlpc_pkg::BEEP_CNT_W;

    tlpc_pkg::cfg_t cfg;

    tlpc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input stage
    logic in_valid_reg;
    logic btn_reg;
    logic advance;

    // state
    tlpc_pkg::phase_t   phase_reg,  phase_next;
    logic [1:0]         saved_reg,  saved_next;
    logic [MS_W-1:0]    ms_reg,     ms_next;
    logic [SLOTS_W-1:0] slot_reg,   slot_next;
    logic [BC_W-1:0]    beep_reg,   beep_next;
    logic               resume_reg, resume_next;

    // result stage
    logic       out_valid_reg;
    logic [7:0] out_data_reg, out_data_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // car phase lookups: saved code 3 and any non-car phase act as red
    function automatic logic [1:0] car_idx(input logic [2:0] p);
        car_idx = (p > 3'(tlpc_pkg::PH_RED)) ? 2'(tlpc_pkg::PH_RED) : p[1:0];
    endfunction

    logic               btn;
    tlpc_pkg::phase_t   ph;
    logic [MS_W-1:0]    ms0;
    logic [SLOTS_W-1:0] slot1;
    logic [1:0]         ci;
    logic [MS_W-1:0]    ilen;
    logic [SLOTS_W-1:0] snum;
    logic [MS_W:0]      ms_inc;
    logic [SLOTS_W:0]   slot_inc;
    logic [9:0]         slen_raw;
    logic [SLOTS_W-1:0] snum_raw;

    always_comb
    begin
        btn         = btn_reg;
        ph          = phase_reg;
        ms0         = ms_reg;
        slot1       = slot_reg;
        saved_next  = saved_reg;
        beep_next   = beep_reg;
        resume_next = resume_reg;

        // decision after a completed beep
        if (ph == tlpc_pkg::PH_BEEP_ON && ms0 == '0 && beep_reg != '0 &&
            (btn || beep_reg >= tlpc_pkg::BEEP_CYCLES))
        begin
            beep_next = '0;
            if (resume_reg)
            begin
                resume_next = 1'b0;
                ph          = tlpc_pkg::PH_RESUME;
            end
            else
            begin
                ph    = tlpc_pkg::PH_GREEN;
                slot1 = '0;
            end
        end

        // button sampled at the start of each car slot
        if (ph <= tlpc_pkg::PH_RED && ms0 == '0 && btn)
        begin
            resume_next = !(ph == tlpc_pkg::PH_GREEN && slot1 == '0);
            saved_next  = ph[1:0];
            ph          = tlpc_pkg::PH_WARN;
        end

        ci = (ph == tlpc_pkg::PH_RESUME) ? car_idx({1'b0, saved_next}) : car_idx(ph);
        case (ci)
            2'd0:
            begin
                slen_raw = cfg.green_slot_ms;
                snum_raw = cfg.green_slots;
            end
            2'd1:
            begin
                slen_raw = cfg.yellow_slot_ms;
                snum_raw = cfg.yellow_slots;
            end
            default:
            begin
                slen_raw = cfg.red_slot_ms;
                snum_raw = cfg.red_slots;
            end
        endcase
        snum = (snum_raw == '0) ? SLOTS_W'(1) : snum_raw;

        case (ph)
            tlpc_pkg::PH_WARN:
                ilen = (cfg.warn_ms == '0) ? MS_W'(1) : cfg.warn_ms;
            tlpc_pkg::PH_BEEP_ON, tlpc_pkg::PH_BEEP_OFF:
                ilen = (cfg.beep_half_ms == '0) ? MS_W'(1) : MS_W'(cfg.beep_half_ms);
            default:
                ilen = (slen_raw == '0) ? MS_W'(1) : MS_W'(slen_raw);
        endcase

        out_data_next = {ph,
                         ph == tlpc_pkg::PH_BEEP_ON,
                         ph == tlpc_pkg::PH_BEEP_ON || ph == tlpc_pkg::PH_BEEP_OFF,
                         ph == tlpc_pkg::PH_GREEN,
                         ph == tlpc_pkg::PH_YELLOW || ph == tlpc_pkg::PH_WARN,
                         ph == tlpc_pkg::PH_RED || ph >= tlpc_pkg::PH_BEEP_ON};

        ms_inc     = {1'b0, ms0} + 1'b1;
        slot_inc   = {1'b0, slot1} + 1'b1;
        phase_next = ph;
        slot_next  = slot1;
        ms_next    = ms_inc[MS_W-1:0];

        if (ms_inc >= {1'b0, ilen})
        begin
            ms_next = '0;
            case (ph)
                tlpc_pkg::PH_WARN:
                begin
                    phase_next = tlpc_pkg::PH_BEEP_ON;
                    beep_next  = '0;
                end
                tlpc_pkg::PH_BEEP_ON:
                    phase_next = tlpc_pkg::PH_BEEP_OFF;
                tlpc_pkg::PH_BEEP_OFF:
                begin
                    phase_next = tlpc_pkg::PH_BEEP_ON;
                    if (beep_reg < tlpc_pkg::BEEP_CNT_MAX)
                        beep_next = beep_reg + 1'b1;
                end
                default:
                begin
                    // green, yellow, red and the resumed slot: next car slot
                    if (slot_inc >= {1'b0, snum})
                    begin
                        slot_next  = '0;
                        phase_next = (ci == 2'(tlpc_pkg::PH_RED)) ?
                                     tlpc_pkg::PH_GREEN :
                                     tlpc_pkg::phase_t'({1'b0, ci + 2'd1});
                    end
                    else
                    begin
                        slot_next  = slot_inc[SLOTS_W-1:0];
                        phase_next = tlpc_pkg::phase_t'({1'b0, ci});
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= tlpc_pkg::PH_GREEN;
            saved_reg     <= 2'(tlpc_pkg::PH_GREEN);
            ms_reg        <= '0;
            slot_reg      <= '0;
            beep_reg      <= '0;
            resume_reg    <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                phase_reg  <= phase_next;
                saved_reg  <= saved_next;
                ms_reg     <= ms_next;
                slot_reg   <= slot_next;
                beep_reg   <= beep_next;
                resume_reg <= resume_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            btn_reg <= s_tdata[0];
        if (advance)
            out_data_reg <= out_data_next;
    end

endmodule

### hdl/tlpc_cfg_regs.sv
// Configuration register file for the traffic light controller.
// Depends on tlpc_pkg.
`timescale 1ns / 1ps

module tlpc_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tlpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tlpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tlpc_pkg::cfg_t                   cfg
);

    tlpc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.green_slot_ms  <= tlpc_pkg::RST_GREEN_SLOT_MS;
            cfg_reg.green_slots    <= tlpc_pkg::RST_GREEN_SLOTS;
            cfg_reg.yellow_slot_ms <= tlpc_pkg::RST_YELLOW_SLOT_MS;
            cfg_reg.yellow_slots   <= tlpc_pkg::RST_YELLOW_SLOTS;
            cfg_reg.red_slot_ms    <= tlpc_pkg::RST_RED_SLOT_MS;
            cfg_reg.red_slots      <= tlpc_pkg::RST_RED_SLOTS;
            cfg_reg.warn_ms        <= tlpc_pkg::RST_WARN_MS;
            cfg_reg.beep_half_ms   <= tlpc_pkg::RST_BEEP_HALF_MS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tlpc_pkg::REG_GREEN_SLOT_MS:
                    cfg_reg.green_slot_ms <= cfg_data[tlpc_pkg::SLOT_MS_W-1:0];
                tlpc_pkg::REG_GREEN_SLOTS:
                    cfg_reg.green_slots <= cfg_data[tlpc_pkg::SLOTS_W-1:0];
                tlpc_pkg::REG_YELLOW_SLOT_MS:
                    cfg_reg.yellow_slot_ms <= cfg_data[tlpc_pkg::SLOT_MS_W-1:0];
                tlpc_pkg::REG_YELLOW_SLOTS:
                    cfg_reg.yellow_slots <= cfg_data[tlpc_pkg::SLOTS_W-1:0];
                tlpc_pkg::REG_RED_SLOT_MS:
                    cfg_reg.red_slot_ms <= cfg_data[tlpc_pkg::SLOT_MS_W-1:0];
                tlpc_pkg::REG_RED_SLOTS:
                    cfg_reg.red_slots <= cfg_data[tlpc_pkg::SLOTS_W-1:0];
                tlpc_pkg::REG_WARN_MS:
                    cfg_reg.warn_ms <= cfg_data[tlpc_pkg::WARN_MS_W-1:0];
                tlpc_pkg::REG_BEEP_HALF_MS:
                    cfg_reg.beep_half_ms <= cfg_data[tlpc_pkg::BEEP_MS_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

### hdl/tlpc_checker.sv
// Port-level checks for the traffic light controller, bound to the top level.
// Depends on tlpc_pkg and traffic_light_pedestrian_controller_top.
`timescale 1ns / 1ps

module tlpc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // exactly one car lamp lit
    a_one_car_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot(m_tdata[2:0]))
        else $error("car lamps not one-hot");

    // walk only while cars see red
    a_walk_red: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[0])
        else $error("walk lamp without car red");

    // buzzer only during the walk phase, and only in the beep-on phase
    a_buzzer: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |->
            m_tdata[3] && m_tdata[7:5] == 3'(tlpc_pkg::PH_BEEP_ON))
        else $error("buzzer outside beep-on");

endmodule

bind traffic_light_pedestrian_controller_top tlpc_checker u_tlpc_checker (.*);
